>>> hdl/nai_pkg.sv
`default_nettype none

package nai_pkg;

    // field and datapath widths
    localparam int SAMPLE_W = 12;
    localparam int SUM_W    = 16;
    localparam int COUNT_W  = 4;
    localparam int TEMP_W   = 19;
    localparam int INDEX_W  = 6;
    localparam int SPAN_W   = 8;
    localparam int PROD_W   = 21;

    // defaults for the top-level parameters
    localparam int SAMPLES_PER_AVERAGE_DEF = 10;
    localparam int TABLE_ENTRIES_DEF       = 45;

    // table geometry
    localparam int STORED_ENTRIES = 45;
    localparam int QUEUE_DEPTH    = 2;
    localparam int TEMP_STEP      = 5000;

    localparam logic signed [TEMP_W-1:0] FIRST_TEMP = -19'sd70000;

    typedef logic [SAMPLE_W-1:0]      sample_t;
    typedef logic [SUM_W-1:0]         sum_t;
    typedef logic signed [TEMP_W-1:0] temp_t;
    typedef logic [INDEX_W-1:0]       index_t;

    typedef struct packed {
        temp_t temp;
        logic  clamped;
    } result_t;

    // divider request and response
    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] dividend;
        logic [SPAN_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [PROD_W-1:0] quotient;
    } div_rsp_t;

    // thermistor counts, falling, one entry per 5 C from -70 C
    function automatic sample_t count_at(input index_t idx);
        sample_t c;
        case (idx)
            6'd0:    c = 12'd4085;
            6'd1:    c = 12'd4080;
            6'd2:    c = 12'd4072;
            6'd3:    c = 12'd4061;
            6'd4:    c = 12'd4045;
            6'd5:    c = 12'd4022;
            6'd6:    c = 12'd3990;
            6'd7:    c = 12'd3948;
            6'd8:    c = 12'd3893;
            6'd9:    c = 12'd3821;
            6'd10:   c = 12'd3730;
            6'd11:   c = 12'd3618;
            6'd12:   c = 12'd3483;
            6'd13:   c = 12'd3325;
            6'd14:   c = 12'd3145;
            6'd15:   c = 12'd2945;
            6'd16:   c = 12'd2729;
            6'd17:   c = 12'd2504;
            6'd18:   c = 12'd2274;
            6'd19:   c = 12'd2047;
            6'd20:   c = 12'd1827;
            6'd21:   c = 12'd1619;
            6'd22:   c = 12'd1426;
            6'd23:   c = 12'd1250;
            6'd24:   c = 12'd1091;
            6'd25:   c = 12'd950;
            6'd26:   c = 12'd826;
            6'd27:   c = 12'd718;
            6'd28:   c = 12'd624;
            6'd29:   c = 12'd542;
            6'd30:   c = 12'd472;
            6'd31:   c = 12'd411;
            6'd32:   c = 12'd359;
            6'd33:   c = 12'd314;
            6'd34:   c = 12'd275;
            6'd35:   c = 12'd242;
            6'd36:   c = 12'd213;
            6'd37:   c = 12'd188;
            6'd38:   c = 12'd166;
            6'd39:   c = 12'd147;
            6'd40:   c = 12'd131;
            6'd41:   c = 12'd117;
            6'd42:   c = 12'd104;
            6'd43:   c = 12'd93;
            6'd44:   c = 12'd84;
            default: c = 12'd0;
        endcase
        return c;
    endfunction

    // temperature of a table entry in milli-degrees
    function automatic temp_t entry_temp(input index_t idx);
        logic [TEMP_W-1:0] off;
        off = TEMP_W'(idx) * TEMP_W'(TEMP_STEP);
        return FIRST_TEMP + $signed(off);
    endfunction

endpackage

`default_nettype wire

>>> hdl/nai_fifo.sv
`default_nettype none

module nai_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == DEPTH_CNT);
    assign empty   = (count_reg == '0);
    assign do_push = push & ~full;
    assign do_pop  = pop & ~empty;
    assign rdata   = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

>>> hdl/nai_front.sv
`default_nettype none

module nai_front #(
    parameter int SAMPLES_PER_AVERAGE = nai_pkg::SAMPLES_PER_AVERAGE_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire nai_pkg::sample_t adc_sample,
    output logic                  full,
    output logic                  q_push,
    output nai_pkg::sum_t         q_data,
    input  wire logic             q_full
);

    localparam logic [nai_pkg::COUNT_W:0] LIMIT =
        (nai_pkg::COUNT_W + 1)'(SAMPLES_PER_AVERAGE);

    nai_pkg::sum_t                sum_reg, sum_next;
    logic [nai_pkg::COUNT_W-1:0]  count_reg, count_next;
    nai_pkg::sum_t                sum_inc;
    logic [nai_pkg::COUNT_W-1:0]  count_inc;
    logic                         accept;
    logic                         complete;

    // a beat is taken only when a finished sum can be queued
    assign full   = q_full;
    assign accept = push & ~q_full;

    assign sum_inc   = sum_reg + nai_pkg::SUM_W'(adc_sample);
    assign count_inc = count_reg + 1'b1;
    assign complete  = (count_inc == '0) || ({1'b0, count_inc} >= LIMIT);

    assign q_push = accept & complete;
    assign q_data = sum_inc;

    // running sum and count
    always_comb
    begin
        sum_next   = sum_reg;
        count_next = count_reg;
        if (accept)
        begin
            if (complete)
            begin
                sum_next   = '0;
                count_next = '0;
            end
            else
            begin
                sum_next   = sum_inc;
                count_next = count_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            sum_reg   <= sum_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/nai_div.sv
`default_nettype none

module nai_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire nai_pkg::div_req_t req,
    output nai_pkg::div_rsp_t      rsp
);

    localparam int DW     = nai_pkg::PROD_W;
    localparam int VW     = nai_pkg::SPAN_W;
    localparam int STEP_W = $clog2(DW + 1);

    logic [VW-1:0]     rem_reg;
    logic [DW-1:0]     quo_reg;
    logic [VW-1:0]     dvs_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [VW:0]       shifted;
    logic [VW:0]       diff;
    logic              q_bit;
    logic [VW-1:0]     rem_next;

    // one restoring step per cycle, quotient bits shift in from the right
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[DW-1]};
        diff     = shifted - {1'b0, dvs_reg};
        q_bit    = ~diff[VW];
        rem_next = q_bit ? diff[VW-1:0] : shifted[VW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (req.start)
        begin
            step_reg <= STEP_W'(DW);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DW-2:0], q_bit};
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

>>> hdl/nai_back.sv
`default_nettype none

module nai_back #(
    parameter int SAMPLES_PER_AVERAGE = nai_pkg::SAMPLES_PER_AVERAGE_DEF,
    parameter int TABLE_ENTRIES       = nai_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_empty,
    input  wire nai_pkg::sum_t     in_data,
    output logic                   in_pop,
    output nai_pkg::div_req_t      div_req,
    input  wire nai_pkg::div_rsp_t div_rsp,
    input  wire logic              res_full,
    output logic                   res_push,
    output nai_pkg::result_t       res_data
);

    localparam int USED_ENTRIES = (TABLE_ENTRIES < nai_pkg::STORED_ENTRIES) ?
                                  TABLE_ENTRIES : nai_pkg::STORED_ENTRIES;
    localparam nai_pkg::index_t LAST_INDEX = nai_pkg::INDEX_W'(USED_ENTRIES - 1);
    localparam int QUO_W = 13;

    // average = (sum * ceil(2^shift / n)) >> shift, exact for every 16-bit sum
    localparam int     AVG_SHIFT  = nai_pkg::SUM_W + $clog2(SAMPLES_PER_AVERAGE);
    localparam int     RECIP_W    = nai_pkg::SUM_W + 1;
    localparam int     AVG_PROD_W = nai_pkg::SUM_W + RECIP_W;
    localparam longint AVG_RECIP  =
        ((longint'(1) << AVG_SHIFT) + longint'(SAMPLES_PER_AVERAGE) - 1) /
        longint'(SAMPLES_PER_AVERAGE);
    localparam logic [RECIP_W-1:0] AVG_MULT = RECIP_W'(AVG_RECIP);

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd2;
    localparam logic [2:0] S_MULT   = 3'd3;
    localparam logic [2:0] S_START  = 3'd4;
    localparam logic [2:0] S_FRAC   = 3'd5;
    localparam logic [2:0] S_OUT    = 3'd6;

    logic [2:0]                    state_reg, state_next;
    nai_pkg::sample_t              avg_reg, avg_next;
    nai_pkg::index_t               idx_reg, idx_next;
    nai_pkg::sample_t              prev_reg, prev_next;
    logic [nai_pkg::SPAN_W-1:0]    diff_reg, diff_next;
    logic [nai_pkg::SPAN_W-1:0]    span_reg, span_next;
    logic [nai_pkg::PROD_W-1:0]    prod_reg, prod_next;
    nai_pkg::result_t              res_reg, res_next;
    nai_pkg::sample_t              cur;
    nai_pkg::temp_t                base;
    nai_pkg::sample_t              avg_diff;
    nai_pkg::sample_t              span_full;
    logic [AVG_PROD_W-1:0]         avg_prod;
    nai_pkg::sample_t              avg_quo;

    assign cur       = nai_pkg::count_at(idx_reg);
    assign base      = nai_pkg::entry_temp(idx_reg);
    assign avg_diff  = avg_reg - cur;
    assign span_full = prev_reg - cur;
    assign res_data  = res_reg;
    assign avg_prod  = AVG_PROD_W'(in_data) * AVG_PROD_W'(AVG_MULT);
    assign avg_quo   = avg_prod[AVG_SHIFT +: nai_pkg::SAMPLE_W];

    always_comb
    begin
        state_next = state_reg;
        avg_next   = avg_reg;
        idx_next   = idx_reg;
        prev_next  = prev_reg;
        diff_next  = diff_reg;
        span_next  = span_reg;
        prod_next  = prod_reg;
        res_next   = res_reg;
        in_pop     = 1'b0;
        res_push   = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = prod_reg;
        div_req.divisor  = span_reg;

        case (state_reg)
            // take a finished sum and scale it down to the average
            S_IDLE:
            begin
                if (!in_empty)
                begin
                    in_pop     = 1'b1;
                    avg_next   = avg_quo;
                    idx_next   = '0;
                    state_next = S_SEARCH;
                end
            end
            // walk the table one entry per cycle
            S_SEARCH:
            begin
                if (idx_reg == '0 && avg_reg > cur)
                begin
                    res_next.temp    = nai_pkg::FIRST_TEMP;
                    res_next.clamped = 1'b1;
                    state_next       = S_OUT;
                end
                else if (cur <= avg_reg)
                begin
                    if (cur == avg_reg || idx_reg == '0)
                    begin
                        res_next.temp    = base;
                        res_next.clamped = 1'b0;
                        state_next       = S_OUT;
                    end
                    else
                    begin
                        diff_next  = avg_diff[nai_pkg::SPAN_W-1:0];
                        span_next  = span_full[nai_pkg::SPAN_W-1:0];
                        state_next = S_MULT;
                    end
                end
                else if (idx_reg == LAST_INDEX)
                begin
                    // average below the last entry in use
                    res_next.temp    = base;
                    res_next.clamped = 1'b1;
                    state_next       = S_OUT;
                end
                else
                begin
                    prev_next = cur;
                    idx_next  = idx_reg + 1'b1;
                end
            end
            S_MULT:
            begin
                prod_next  = nai_pkg::PROD_W'(diff_reg) *
                             nai_pkg::PROD_W'(nai_pkg::TEMP_STEP);
                state_next = S_START;
            end
            S_START:
            begin
                div_req.start = 1'b1;
                state_next    = S_FRAC;
            end
            // interpolate back from the lower entry
            S_FRAC:
            begin
                if (div_rsp.done)
                begin
                    res_next.temp = base - $signed(nai_pkg::TEMP_W'(
                                        div_rsp.quotient[QUO_W-1:0]));
                    res_next.clamped = 1'b0;
                    state_next       = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        avg_reg  <= avg_next;
        idx_reg  <= idx_next;
        prev_reg <= prev_next;
        diff_reg <= diff_next;
        span_reg <= span_next;
        prod_reg <= prod_next;
        res_reg  <= res_next;
    end

endmodule

`default_nettype wire

>>> hdl/ntc_average_and_interpolate.sv
// Path to a result: the beat that completes an average queues its sum; the back
//   pops and scales the sum, walks up to 45 table entries, multiplies and runs
//   the 21-step divide unless the average hits an entry or clamps, then queues the result.
// Throughput: one sample beat per cycle into the front while the sum queue has
//   room; the back sequencer takes one sum at a time, and two sums queue.
// Reset: asynchronous, active low; clears the sum, count, queues and sequencer.
`default_nettype none

module ntc_average_and_interpolate #(
    parameter int SAMPLES_PER_AVERAGE = nai_pkg::SAMPLES_PER_AVERAGE_DEF,
    parameter int TABLE_ENTRIES       = nai_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire nai_pkg::sample_t adc_sample,
    output logic                  empty,
    input  wire logic             pop,
    output nai_pkg::temp_t        temperature_milli_c,
    output logic                  clamped
);

    logic                         sum_push;
    nai_pkg::sum_t                sum_wdata;
    logic                         sum_full;
    logic                         sum_pop;
    nai_pkg::sum_t                sum_rdata;
    logic                         sum_empty;
    nai_pkg::div_req_t            div_req;
    nai_pkg::div_rsp_t            div_rsp;
    logic                         res_push;
    nai_pkg::result_t             res_wdata;
    logic                         res_full;
    logic [$bits(nai_pkg::result_t)-1:0] res_rdata;
    nai_pkg::result_t             res_head;

    // front: accumulate samples
    nai_front #(
        .SAMPLES_PER_AVERAGE(SAMPLES_PER_AVERAGE)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .adc_sample (adc_sample),
        .full       (full),
        .q_push     (sum_push),
        .q_data     (sum_wdata),
        .q_full     (sum_full)
    );

    // finished sums waiting for the back end
    nai_fifo #(
        .WIDTH(nai_pkg::SUM_W),
        .DEPTH(nai_pkg::QUEUE_DEPTH)
    ) u_sum_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (sum_push),
        .wdata (sum_wdata),
        .full  (sum_full),
        .pop   (sum_pop),
        .rdata (sum_rdata),
        .empty (sum_empty)
    );

    // back: average, search, interpolate
    nai_back #(
        .SAMPLES_PER_AVERAGE(SAMPLES_PER_AVERAGE),
        .TABLE_ENTRIES      (TABLE_ENTRIES)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_empty (sum_empty),
        .in_data  (sum_rdata),
        .in_pop   (sum_pop),
        .div_req  (div_req),
        .div_rsp  (div_rsp),
        .res_full (res_full),
        .res_push (res_push),
        .res_data (res_wdata)
    );

    // interpolation divider
    nai_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // result queue
    nai_fifo #(
        .WIDTH($bits(nai_pkg::result_t)),
        .DEPTH(nai_pkg::QUEUE_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_wdata),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_rdata),
        .empty (empty)
    );

    assign res_head            = nai_pkg::result_t'(res_rdata);
    assign temperature_milli_c = res_head.temp;
    assign clamped             = res_head.clamped;

    // results only go into a queue with room
    a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result pushed into full queue");

    // a pushed result is visible on the next cycle
    a_res_visible: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |=> !empty)
        else $error("pushed result not visible");

    // divider finishes only after running
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> $past(div_rsp.busy))
        else $error("divider done without running");

    // no new divide is started while one is in flight
    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider restarted while busy");

endmodule

`default_nettype wire

>>> verif/ntc_average_and_interpolate_test.sv
`default_nettype none

module ntc_average_and_interpolate_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_AVG      = nai_pkg::SAMPLES_PER_AVERAGE_DEF;
    localparam int N_ENTRIES  = nai_pkg::TABLE_ENTRIES_DEF;
    localparam int N_USED     = (N_ENTRIES < 45) ? N_ENTRIES : 45;
    localparam int IDLE_LIMIT = 20000;
    localparam int TAIL_WAIT  = 150;
    localparam int MAX_SHOWN  = 10;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             push = 1'b0;
    nai_pkg::sample_t adc_sample = '0;
    logic             pop = 1'b0;
    logic             full;
    logic             empty;
    nai_pkg::temp_t   temperature_milli_c;
    logic             clamped;

    // thermistor counts, one per 5 C step starting at -70 C
    int ntc_counts [0:44] = '{
        4085, 4080, 4072, 4061, 4045, 4022, 3990, 3948, 3893, 3821,
        3730, 3618, 3483, 3325, 3145, 2945, 2729, 2504, 2274, 2047,
        1827, 1619, 1426, 1250, 1091,  950,  826,  718,  624,  542,
         472,  411,  359,  314,  275,  242,  213,  188,  166,  147,
         131,  117,  104,   93,   84
    };

    // running accumulator mirror and pending temperatures
    logic [nai_pkg::SUM_W-1:0]   acc_sum = '0;
    logic [nai_pkg::COUNT_W-1:0] acc_count = '0;
    nai_pkg::result_t            expected_temps[$];

    int  errors = 0;
    bit  tx_idle = 1'b0;
    bit  rx_idle = 1'b0;
    int  rx_hold = 0;

    ntc_average_and_interpolate #(
        .SAMPLES_PER_AVERAGE(N_AVG),
        .TABLE_ENTRIES      (N_ENTRIES)
    ) dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .push               (push),
        .full               (full),
        .adc_sample         (adc_sample),
        .empty              (empty),
        .pop                (pop),
        .temperature_milli_c(temperature_milli_c),
        .clamped            (clamped)
    );

    // 12 ns clock
    initial
    begin
        forever
        begin
            #6 clk = ~clk;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99, 0);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(3, 1);
        else
            return $urandom_range(150, 10);
    endfunction

    // table search and linear interpolation of one average
    function automatic nai_pkg::result_t average_to_temp(input int avg);
        nai_pkg::result_t res;
        int      idx;
        int      span;
        int      t;
        res.clamped = 1'b0;
        idx = N_USED;
        for (int k = N_USED - 1; k >= 0; k--)
        begin
            if (ntc_counts[k] <= avg)
                idx = k;
        end
        if (avg > ntc_counts[0])
        begin
            t = -70000;
            res.clamped = 1'b1;
        end
        else if (idx >= N_USED)
        begin
            t = -70000 + 5000 * (N_USED - 1);
            res.clamped = 1'b1;
        end
        else if (ntc_counts[idx] == avg || idx == 0)
        begin
            t = -70000 + 5000 * idx;
        end
        else
        begin
            span = ntc_counts[idx - 1] - ntc_counts[idx];
            t = -70000 + 5000 * idx - (5000 * (avg - ntc_counts[idx])) / span;
        end
        res.temp = nai_pkg::temp_t'(t);
        return res;
    endfunction

    // accumulate one accepted sample; every N_AVG samples yields a temperature
    task automatic accumulate(input nai_pkg::sample_t s);
        acc_sum = acc_sum + nai_pkg::SUM_W'(s);
        acc_count = acc_count + 1'b1;
        if (acc_count == 0 || acc_count >= N_AVG)
        begin
            expected_temps.push_back(average_to_temp(int'(acc_sum) / N_AVG));
            acc_sum = '0;
            acc_count = '0;
        end
    endtask

    // offer one sample beat and wait until it is taken
    task automatic send_sample(input nai_pkg::sample_t s);
        int gap;
        gap = tx_idle ? pick_gap() : 0;
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        adc_sample <= s;
        do
            @(posedge clk);
        while (full);
        accumulate(s);
    endtask

    // ten samples scattered around a target whose sum lands near target*N_AVG
    task automatic send_average(input int target, input int spread);
        int total;
        int s;
        int lo;
        int hi;
        total = target * N_AVG + $urandom_range(N_AVG - 1, 0);
        lo = (target - spread < 0) ? 0 : target - spread;
        hi = (target + spread > 4095) ? 4095 : target + spread;
        for (int k = 0; k < N_AVG - 1; k++)
        begin
            s = $urandom_range(hi, lo);
            total -= s;
            send_sample(nai_pkg::sample_t'(s));
        end
        if (total < 0)
            total = 0;
        if (total > 4095)
            total = 4095;
        send_sample(nai_pkg::sample_t'(total));
    endtask

    // sender holds off until every pending temperature is out
    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (expected_temps.size() != 0)
            @(posedge clk);
    endtask

    // random target: near a table entry, at a boundary, or anywhere
    function automatic int random_target();
        int r;
        int t;
        r = $urandom_range(99, 0);
        if (r < 35)
            t = ntc_counts[$urandom_range(44, 0)] + $urandom_range(4, 0) - 2;
        else if (r < 45)
        begin
            case ($urandom_range(5, 0))
                0:       t = 0;
                1:       t = 83;
                2:       t = 84;
                3:       t = 4085;
                4:       t = 4086;
                default: t = 4095;
            endcase
        end
        else
            t = $urandom_range(4095, 0);
        if (t < 0)
            t = 0;
        if (t > 4095)
            t = 4095;
        return t;
    endfunction

    // pop driver: random gaps, plus an optional long hold-off
    initial
    begin
        int rx_gap;
        rx_gap = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (pop && !empty && rx_idle)
                rx_gap = pick_gap();
            if (rx_hold > 0)
            begin
                rx_hold--;
                pop <= 1'b0;
            end
            else if (rx_gap > 0)
            begin
                rx_gap--;
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    // result checker: each popped beat against the oldest pending temperature
    always @(posedge clk)
    begin
        nai_pkg::result_t want;
        if (rst_n && pop && !empty)
        begin
            if (expected_temps.size() == 0)
            begin
                errors++;
                if (errors <= MAX_SHOWN)
                    $display("unexpected beat: temp=%0d clamped=%0b",
                             temperature_milli_c, clamped);
            end
            else
            begin
                want = expected_temps.pop_front();
                if (temperature_milli_c !== want.temp || clamped !== want.clamped)
                begin
                    errors++;
                    if (errors <= MAX_SHOWN)
                        $display("mismatch: temp exp=%0d got=%0d, clamped exp=%0b got=%0b",
                                 want.temp, temperature_milli_c, want.clamped, clamped);
                end
            end
        end
    end

    // watchdog: too long without any beat on either side
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty) || !rst_n)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("** ntc_average_and_interpolate: FAILED **");
        $finish;
    end

    // both ends of the table, exact hits and clamping
    task automatic test_table_ends();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        send_average(4095, 0);
        send_average(4085, 0);
        send_average(84, 0);
        send_average(0, 0);
    endtask

    // averages that fall between entries, with a remainder dropped by the divide
    task automatic test_interpolation();
        for (int k = 0; k < N_AVG - 1; k++)
            send_sample(nai_pkg::sample_t'(2046));
        send_sample(nai_pkg::sample_t'(2055));
        send_average(3000, 1000);
    endtask

    // long receiver stall while the sender keeps offering back to back
    task automatic test_backpressure();
        tx_idle = 1'b0;
        rx_hold = 2000;
        for (int k = 0; k < 10; k++)
            send_average(random_target(), 50);
    endtask

    // random averages with both sides running flat out
    task automatic test_random_streaming();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        for (int k = 0; k < 40; k++)
            send_average(random_target(), ($urandom_range(3, 0) == 0) ? 0 : 300);
    endtask

    // random averages with idling on both sides
    task automatic test_random_gaps();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        for (int k = 0; k < 120; k++)
            send_average(random_target(), $urandom_range(300, 0));
    endtask

    // fully random samples; every input bit toggles
    task automatic test_raw_samples();
        for (int k = 0; k < 100; k++)
            send_sample(nai_pkg::sample_t'($urandom_range(4095, 0)));
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_table_ends();
        test_interpolation();
        drain();
        test_backpressure();
        drain();
        test_random_streaming();
        test_random_gaps();
        test_raw_samples();
        drain();

        repeat (TAIL_WAIT) @(posedge clk);
        if (expected_temps.size() != 0)
            errors++;
        if (errors == 0)
            $display("** ntc_average_and_interpolate: PASSED **");
        else
            $display("** ntc_average_and_interpolate: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
hdl/nai_pkg.sv
hdl/nai_fifo.sv
hdl/nai_front.sv
hdl/nai_div.sv
hdl/nai_back.sv
hdl/ntc_average_and_interpolate.sv
verif/ntc_average_and_interpolate_test.sv
